// ----- hw/rtl/lpe_pkg.sv -----
// Package for the Legendre polynomial evaluator: field widths, fixed-point
// constants, microcode word types and the step program.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpe_pkg;

   localparam int DEG_W              = 6;
   localparam int DATA_W             = 32;
   localparam int FRAC_BITS          = 30;
   localparam int RECIP_BITS         = 62;
   localparam int MAG_W              = FRAC_BITS + 1;
   localparam int DEFAULT_MAX_DEGREE = 32;
   localparam int UPC_W              = 3;

   localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(64'd1 << FRAC_BITS);

   typedef enum logic [2:0] {
      MUL_ZC,
      MUL_TL,
      MUL_TH,
      MUL_PL,
      MUL_PH
   } mul_sel_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_T,
      OP_ACC,
      OP_V,
      OP_U,
      OP_STEP
   } op_type;

   typedef enum logic [0:0] {
      JMP_NEXT,
      JMP_LOOP
   } jmp_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      op_type      op;
      jmp_type     jmp;
   } ucode_type;

   // One recurrence step: z*P_k, then P_{k-1}*w and t*w in two halves each.
   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type word;
      case (addr)
         3'd0: word = '{mul_sel: MUL_ZC, op: OP_NONE, jmp: JMP_NEXT};
         3'd1: word = '{mul_sel: MUL_PL, op: OP_T,    jmp: JMP_NEXT};
         3'd2: word = '{mul_sel: MUL_PH, op: OP_ACC,  jmp: JMP_NEXT};
         3'd3: word = '{mul_sel: MUL_TL, op: OP_V,    jmp: JMP_NEXT};
         3'd4: word = '{mul_sel: MUL_TH, op: OP_ACC,  jmp: JMP_NEXT};
         3'd5: word = '{mul_sel: MUL_ZC, op: OP_U,    jmp: JMP_NEXT};
         3'd6: word = '{mul_sel: MUL_ZC, op: OP_STEP, jmp: JMP_LOOP};
         default: word = '{mul_sel: MUL_ZC, op: OP_NONE, jmp: JMP_LOOP};
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lpe_if.sv -----
// Valid/ready channel interfaces for the request and response transactions
// of the Legendre polynomial evaluator. Depends on lpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lpe_req_if import lpe_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [DEG_W-1:0]         degree;
   logic signed [DATA_W-1:0] arg_value;

   modport source (output valid, output degree, output arg_value, input ready);
   modport sink   (input valid, input degree, input arg_value, output ready);
endinterface

interface lpe_rsp_if import lpe_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] poly_value;

   modport source (output valid, output poly_value, input ready);
   modport sink   (input valid, input poly_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/legendre_polynomial_eval_core.sv -----
// Legendre polynomial evaluator P_n(z), microcoded over one shared 32x32
// multiplier. Depends on lpe_pkg and the channel interfaces in lpe_if.
//
// One request transaction (degree n, argument z in Q2.30) yields one response
// transaction P_n(z) in Q2.30, saturated to +-1.0; z is clamped to [-1,1] and
// n to MAX_DEGREE. A request is taken only while no evaluation is running; a
// finished result waits in the output register while the next request is
// accepted. Degrees zero and one skip the recurrence and go straight to the
// pending state. Degree n >= 2 runs n-1 recurrence steps of seven microcode
// words each, set by the shared multiplier (z*P_k plus two half products for
// each of t*w and P_{k-1}*w). From the pending state the result is loaded into
// the output register once the previous one has been taken, and then a new
// request can be accepted.
`timescale 1ns / 1ps
`default_nettype none

module legendre_polynomial_eval_core import lpe_pkg::*; #(
   parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lpe_req_if.sink    req_chan,
   lpe_rsp_if.source  rsp_chan
);

   localparam int DEG_LIMIT = (1 << DEG_W) - 1;
   localparam int EFF_MAX   = (MAX_DEGREE > DEG_LIMIT) ? DEG_LIMIT : MAX_DEGREE;
   localparam int NW        = $clog2(EFF_MAX + 1);
   localparam int KW        = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_PEND = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [UPC_W-1:0]         upc_ff, upc_in;
   logic [NW-1:0]            n_ff, n_in;
   logic [NW-1:0]            k_ff, k_in;
   logic signed [DATA_W-1:0] z_ff, z_in;
   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic signed [DATA_W-1:0] t_ff, t_in;
   logic signed [DATA_W-1:0] u_ff, u_in;
   logic signed [DATA_W-1:0] v_ff, v_in;
   logic [63:0]              acc_ff, acc_in;
   logic [63:0]              prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] out_ff, out_in;

   ucode_type                uc;
   logic [RECIP_BITS-1:0]    w_rom [EFF_MAX];
   logic [RECIP_BITS-1:0]    w_cur;
   logic [31:0]              mul_a, mul_b;
   logic [MAG_W-1:0]         z_mag, cur_mag, prev_mag, t_mag;
   logic [63:0]              t_rnd;
   logic [95:0]              wide_sum;
   logic [MAG_W-1:0]         wide_mag;
   logic [MAG_W-1:0]         t_new_mag;
   logic signed [33:0]       step_sum;
   logic signed [DATA_W-1:0] step_sat;
   logic signed [DATA_W-1:0] z_sat;
   logic [NW-1:0]            n_req;
   logic [NW-1:0]            k_next;
   logic                     req_fire;

   // k/(k+1) in Q62 for k = 0 .. EFF_MAX-1
   for (genvar i = 0; i < EFF_MAX; i++) begin : g_wrom
      localparam logic [63:0] RCP = ((64'd1 << RECIP_BITS) + 64'((i + 1) / 2)) / 64'(i + 1);
      assign w_rom[i] = RECIP_BITS'((64'd1 << RECIP_BITS) - RCP);
   end

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [DATA_W-1:0] x);
      logic [DATA_W-1:0] a;
      a = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
      return a[MAG_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] apply_sign(input logic neg,
                                                           input logic [MAG_W-1:0] m);
      logic [DATA_W-1:0] e;
      e = DATA_W'(m);
      return neg ? -$signed(e) : $signed(e);
   endfunction

   assign uc       = ucode_rom(upc_ff);
   assign w_cur    = w_rom[k_ff[KW-1:0]];
   assign z_mag    = mag_of(z_ff);
   assign cur_mag  = mag_of(cur_ff);
   assign prev_mag = mag_of(prev_ff);
   assign t_mag    = mag_of(t_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uc.mul_sel)
         MUL_ZC: begin
            mul_a = 32'(z_mag);
            mul_b = 32'(cur_mag);
         end
         MUL_TL: begin
            mul_a = 32'(t_mag);
            mul_b = w_cur[31:0];
         end
         MUL_TH: begin
            mul_a = 32'(t_mag);
            mul_b = 32'(w_cur[RECIP_BITS-1:32]);
         end
         MUL_PL: begin
            mul_a = 32'(prev_mag);
            mul_b = w_cur[31:0];
         end
         MUL_PH: begin
            mul_a = 32'(prev_mag);
            mul_b = 32'(w_cur[RECIP_BITS-1:32]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in   = 64'(mul_a) * 64'(mul_b);
   assign t_rnd     = prod_ff + (64'd1 << (FRAC_BITS - 1));
   assign t_new_mag = t_rnd[FRAC_BITS+MAG_W-1:FRAC_BITS];
   assign wide_sum  = {32'd0, acc_ff} + {prod_ff, 32'd0} + (96'd1 << (RECIP_BITS - 1));
   assign wide_mag  = wide_sum[RECIP_BITS+MAG_W-1:RECIP_BITS];
   assign step_sum  = 34'(t_ff) + 34'(u_ff) - 34'(v_ff);

   always_comb begin
      if (step_sum > 34'(ONE_Q)) begin
         step_sat = ONE_Q;
      end else if (step_sum < -34'(ONE_Q)) begin
         step_sat = -ONE_Q;
      end else begin
         step_sat = step_sum[DATA_W-1:0];
      end
   end

   always_comb begin
      if (req_chan.arg_value > ONE_Q) begin
         z_sat = ONE_Q;
      end else if (req_chan.arg_value < -ONE_Q) begin
         z_sat = -ONE_Q;
      end else begin
         z_sat = req_chan.arg_value;
      end
   end

   assign n_req    = (req_chan.degree > DEG_W'(EFF_MAX)) ? NW'(EFF_MAX) : NW'(req_chan.degree);
   assign k_next   = k_ff + NW'(1);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.poly_value = out_ff;

   always_comb begin
      state_in     = state_ff;
      upc_in       = upc_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      z_in         = z_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               z_in    = z_sat;
               n_in    = n_req;
               k_in    = NW'(1);
               upc_in  = '0;
               prev_in = ONE_Q;
               cur_in  = (n_req == '0) ? ONE_Q : z_sat;
               state_in = (n_req <= NW'(1)) ? ST_PEND : ST_RUN;
            end
         end
         ST_RUN: begin
            case (uc.op)
               OP_T:    t_in   = apply_sign(z_ff[DATA_W-1] ^ cur_ff[DATA_W-1], t_new_mag);
               OP_ACC:  acc_in = prod_ff;
               OP_V:    v_in   = apply_sign(prev_ff[DATA_W-1], wide_mag);
               OP_U:    u_in   = apply_sign(t_ff[DATA_W-1], wide_mag);
               OP_STEP: begin
                  prev_in = cur_ff;
                  cur_in  = step_sat;
                  k_in    = k_next;
               end
               default: begin
               end
            endcase
            if (uc.jmp == JMP_LOOP) begin
               upc_in = '0;
               if (k_next >= n_ff) begin
                  state_in = ST_PEND;
               end
            end else begin
               upc_in = UPC_W'(upc_ff + UPC_W'(1));
            end
         end
         ST_PEND: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_in       = cur_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      k_ff    <= k_in;
      z_ff    <= z_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      t_ff    <= t_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("request accepted while an evaluation was pending");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (k_ff < n_ff) && (k_ff != '0))
      else $error("recurrence index out of range");

   a_result_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_ff <= ONE_Q) && (out_ff >= -ONE_Q))
      else $error("result beyond +-1.0");

endmodule

`default_nettype wire
